// File: rtl/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg: shared types and constants of the firmware image checker
// Holds the size band limits, the target class codes and the structs that
// carry the processing step, the configuration and the chunk figures.
// ----------------------------------------------------------------------------
package fic_pkg;

   // Starting value of both Fletcher sums.
   localparam logic [15:0] SUM_INIT = 16'hFFFF;

   // Size bands in bytes: the first band wins where they overlap.
   localparam logic [31:0] BAND1_LO = 32'd24576;
   localparam logic [31:0] BAND1_HI = 32'd98304;
   localparam logic [31:0] BAND2_LO = 32'd57344;
   localparam logic [31:0] BAND2_HI = 32'd163840;

   // Target class codes of the result word.
   typedef enum logic [1:0] {
      TARGET_UNKNOWN = 2'd0,
      TARGET_SMALL   = 2'd1,
      TARGET_LARGE   = 2'd2
   } target_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      CSR_MIN_BYTES  = 2'd0,
      CSR_MAX_BYTES  = 2'd1,
      CSR_LOAD_SMALL = 2'd2,
      CSR_LOAD_LARGE = 2'd3
   } csr_index_type;

   // One processing step of the buffered input word.
   typedef struct packed {
      logic       fire;
      logic       last;
      logic [7:0] data_byte;
   } step_type;

   // Configuration registers.
   typedef struct packed {
      logic [19:0] min_bytes;
      logic [19:0] max_bytes;
      logic [31:0] load_small;
      logic [31:0] load_large;
   } cfg_type;

   // Download chunk figures of the image so far.
   typedef struct packed {
      logic [8:0]  chunk_total;
      logic [12:0] tail_bytes;
   } chunk_info_type;

endpackage

// File: rtl/fic_fletcher.sv
// ----------------------------------------------------------------------------
// fic_fletcher: Fletcher-32 accumulator
// Pairs bytes into little-endian words and keeps both sums modulo 0xFFFF.
// A lone final byte is added as a word with a zero high half.
// ----------------------------------------------------------------------------
module fic_fletcher
   import fic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  step_type    step,
   output logic [31:0] checksum
);

   logic [15:0] sum_low_ff, sum_low_in;
   logic [15:0] sum_high_ff, sum_high_in;
   logic [7:0]  held_ff, held_in;
   logic        holding_ff, holding_in;
   logic        add_word;
   logic [15:0] word;
   logic [15:0] low_new, high_new;

   // Reduce a sum of two 16-bit values modulo 0xFFFF; the sum is at most
   // twice the modulus.
   function automatic logic [15:0] mod_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      logic [16:0] r;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 17'h1FFFE) begin
         r = s - 17'h1FFFE;
      end else if (s >= 17'h0FFFF) begin
         r = s - 17'h0FFFF;
      end else begin
         r = s;
      end
      return r[15:0];
   endfunction

   // Word assembly and the two chained sum updates.
   always_comb begin
      add_word = holding_ff || step.last;
      word     = holding_ff ? {step.data_byte, held_ff} : {8'h00, step.data_byte};
      low_new  = mod_add(sum_low_ff, word);
      high_new = mod_add(sum_high_ff, low_new);
      checksum = add_word ? {high_new, low_new} : {sum_high_ff, sum_low_ff};
   end

   // Next state: the image end returns everything to the start values.
   always_comb begin
      sum_low_in  = sum_low_ff;
      sum_high_in = sum_high_ff;
      held_in     = held_ff;
      holding_in  = holding_ff;
      if (step.fire) begin
         if (step.last) begin
            sum_low_in  = SUM_INIT;
            sum_high_in = SUM_INIT;
            held_in     = 8'h00;
            holding_in  = 1'b0;
         end else if (holding_ff) begin
            sum_low_in  = low_new;
            sum_high_in = high_new;
            held_in     = 8'h00;
            holding_in  = 1'b0;
         end else begin
            held_in    = step.data_byte;
            holding_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_low_ff  <= SUM_INIT;
         sum_high_ff <= SUM_INIT;
         held_ff     <= 8'h00;
         holding_ff  <= 1'b0;
      end else begin
         sum_low_ff  <= sum_low_in;
         sum_high_ff <= sum_high_in;
         held_ff     <= held_in;
         holding_ff  <= holding_in;
      end
   end

endmodule

// File: rtl/fic_size_count.sv
// ----------------------------------------------------------------------------
// fic_size_count: image byte counter
// Counts bytes with saturation and tracks the chunk count and the bytes in
// the current chunk incrementally, so no division is needed.
// ----------------------------------------------------------------------------
module fic_size_count
   import fic_pkg::*;
#(
   parameter int CHUNK_BYTES = 4096,
   parameter int SIZE_BITS   = 20
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  step_type             step,
   output logic [SIZE_BITS:0]   size,
   output chunk_info_type       chunk_info
);

   localparam int COUNT_W = SIZE_BITS + 1;
   localparam int TAIL_W  = $clog2(CHUNK_BYTES + 1);
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [TAIL_W-1:0]  TAIL_FULL = TAIL_W'(CHUNK_BYTES);
   localparam logic [TAIL_W-1:0]  TAIL_ONE  = TAIL_W'(1);

   logic [COUNT_W-1:0] count_ff, count_in, count_now;
   logic [TAIL_W-1:0]  tail_ff, tail_in, tail_now;
   logic [8:0]         chunk_ff, chunk_in, chunk_now;
   logic               count_sat;
   logic [31:0]        tail_ext;

   // Count including the current byte; the chunk figures stop with it.
   always_comb begin
      count_sat = (count_ff == COUNT_MAX);
      count_now = count_sat ? count_ff : count_ff + COUNT_W'(1);
      tail_now  = tail_ff;
      chunk_now = chunk_ff;
      if (!count_sat) begin
         if (count_ff == '0) begin
            tail_now  = TAIL_ONE;
            chunk_now = 9'd1;
         end else if (tail_ff == TAIL_FULL) begin
            tail_now  = TAIL_ONE;
            chunk_now = chunk_ff + 9'd1;
         end else begin
            tail_now = tail_ff + TAIL_ONE;
         end
      end
      tail_ext               = 32'(tail_now);
      size                   = count_now;
      chunk_info.chunk_total = chunk_now;
      chunk_info.tail_bytes  = tail_ext[12:0];
   end

   // Next state: cleared once the image end has been seen.
   always_comb begin
      count_in = count_ff;
      tail_in  = tail_ff;
      chunk_in = chunk_ff;
      if (step.fire) begin
         if (step.last) begin
            count_in = '0;
            tail_in  = '0;
            chunk_in = 9'd0;
         end else begin
            count_in = count_now;
            tail_in  = tail_now;
            chunk_in = chunk_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         tail_ff  <= '0;
         chunk_ff <= 9'd0;
      end else begin
         count_ff <= count_in;
         tail_ff  <= tail_in;
         chunk_ff <= chunk_in;
      end
   end

endmodule

// File: rtl/fic_result.sv
// ----------------------------------------------------------------------------
// fic_result: result formatting and output register
// Checks the size range, picks the target class and load address, and holds
// the result word until the consumer takes it.
// ----------------------------------------------------------------------------
module fic_result
   import fic_pkg::*;
#(
   parameter int SIZE_BITS = 20
)
(
   input  logic                clock,
   input  logic                reset,
   input  step_type            step,
   input  logic [SIZE_BITS:0]  size,
   input  chunk_info_type      chunk_info,
   input  logic [31:0]         checksum,
   input  cfg_type             cfg,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic                rsp_status,
   output logic [19:0]         rsp_image_size,
   output logic [1:0]          rsp_target_class,
   output logic [31:0]         rsp_target_addr,
   output logic [31:0]         rsp_checksum,
   output logic [8:0]          rsp_chunk_total,
   output logic [12:0]         rsp_tail_bytes
);

   logic        valid_ff, valid_in;
   logic        status_ff;
   logic [19:0] image_size_ff;
   logic [1:0]  target_class_ff;
   logic [31:0] target_addr_ff;
   logic [31:0] checksum_ff;
   logic [8:0]  chunk_total_ff;
   logic [12:0] tail_bytes_ff;

   logic        load;
   logic        in_range;
   logic [31:0] size_ext;
   logic [31:0] size_mask_ext;
   target_type  target;
   logic [31:0] address;

   // Range check, size bands and load address selection.
   always_comb begin
      load          = step.fire && step.last;
      size_ext      = 32'(size);
      size_mask_ext = 32'(size[SIZE_BITS-1:0]);
      in_range      = (size_ext >= 32'(cfg.min_bytes)) && (size_ext <= 32'(cfg.max_bytes));
      if (size_ext >= BAND1_LO && size_ext <= BAND1_HI) begin
         target  = TARGET_SMALL;
         address = cfg.load_small;
      end else if (size_ext >= BAND2_LO && size_ext <= BAND2_HI) begin
         target  = TARGET_LARGE;
         address = cfg.load_large;
      end else begin
         target  = TARGET_UNKNOWN;
         address = 32'h0000_0000;
      end
   end

   // Output valid: set by a new result, cleared when it is taken.
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload; a corrupt size zeroes everything but the status.
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= !in_range;
         if (in_range) begin
            image_size_ff   <= size_mask_ext[19:0];
            target_class_ff <= target;
            target_addr_ff  <= address;
            checksum_ff     <= checksum;
            chunk_total_ff  <= chunk_info.chunk_total;
            tail_bytes_ff   <= chunk_info.tail_bytes;
         end else begin
            image_size_ff   <= 20'd0;
            target_class_ff <= TARGET_UNKNOWN;
            target_addr_ff  <= 32'h0000_0000;
            checksum_ff     <= 32'h0000_0000;
            chunk_total_ff  <= 9'd0;
            tail_bytes_ff   <= 13'd0;
         end
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_image_size   = image_size_ff;
   assign rsp_target_class = target_class_ff;
   assign rsp_target_addr  = target_addr_ff;
   assign rsp_checksum     = checksum_ff;
   assign rsp_chunk_total  = chunk_total_ff;
   assign rsp_tail_bytes   = tail_bytes_ff;

endmodule

// File: rtl/firmware_image_checker.sv
// ----------------------------------------------------------------------------
// firmware_image_checker: byte stream Fletcher-32 image checker
// Buffers each byte in an input register, updates the checksum and the size
// counters in one step and gives one result word on the final byte.
// ----------------------------------------------------------------------------
// The final byte waits in the input register; its result word is then registered.
// Throughput: one byte per cycle; the final byte waits only while an earlier
// result still sits unread in the output register.
// Reset clears the checksum, the counters and the valid bits of both register
// stages, and loads the configuration registers with their default values.
module firmware_image_checker
   import fic_pkg::*;
#(
   parameter int CHUNK_BYTES = 4096,
   parameter int SIZE_BITS   = 20
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [19:0] rsp_image_size,
   output logic [1:0]  rsp_target_class,
   output logic [31:0] rsp_target_addr,
   output logic [31:0] rsp_checksum,
   output logic [8:0]  rsp_chunk_total,
   output logic [12:0] rsp_tail_bytes,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   cfg_type             cfg_ff, cfg_in;
   logic                in_valid_ff, in_valid_in;
   logic [7:0]          in_byte_ff;
   logic                in_last_ff;
   logic                out_free;
   logic                proc_fire;
   step_type            step;
   logic [SIZE_BITS:0]  size;
   chunk_info_type      chunk_info;
   logic [31:0]         checksum;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_BYTES:  cfg_in.min_bytes  = csr_write_data[19:0];
            CSR_MAX_BYTES:  cfg_in.max_bytes  = csr_write_data[19:0];
            CSR_LOAD_SMALL: cfg_in.load_small = csr_write_data;
            CSR_LOAD_LARGE: cfg_in.load_large = csr_write_data;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_bytes  <= 20'd1024;
         cfg_ff.max_bytes  <= 20'd262144;
         cfg_ff.load_small <= 32'h0050_1000;
         cfg_ff.load_large <= 32'h0090_6000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake: a buffered final byte waits for a free output register.
   always_comb begin
      out_free    = !rsp_valid || rsp_ready;
      proc_fire   = in_valid_ff && (!in_last_ff || out_free);
      req_ready   = !in_valid_ff || proc_fire;
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
      step.fire      = proc_fire;
      step.last      = in_last_ff;
      step.data_byte = in_byte_ff;
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
   end

   fic_fletcher u_fletcher (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .checksum (checksum)
   );

   fic_size_count #(
      .CHUNK_BYTES (CHUNK_BYTES),
      .SIZE_BITS   (SIZE_BITS)
   ) u_size_count (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .size       (size),
      .chunk_info (chunk_info)
   );

   fic_result #(
      .SIZE_BITS (SIZE_BITS)
   ) u_result (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .size             (size),
      .chunk_info       (chunk_info),
      .checksum         (checksum),
      .cfg              (cfg_ff),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_image_size   (rsp_image_size),
      .rsp_target_class (rsp_target_class),
      .rsp_target_addr  (rsp_target_addr),
      .rsp_checksum     (rsp_checksum),
      .rsp_chunk_total  (rsp_chunk_total),
      .rsp_tail_bytes   (rsp_tail_bytes)
   );

   // A buffered word that is not processed stays put.
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !proc_fire |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("buffered input word changed before it was processed");

   // Processing a final byte always produces a result word.
   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      proc_fire && in_last_ff |=> rsp_valid)
      else $error("final byte processed without a result word");

   // A new result word only appears after a final byte.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(proc_fire && in_last_ff))
      else $error("result word without a final byte");

   // A stalled result blocks a buffered final byte and new input.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && in_valid_ff && in_last_ff |-> !req_ready && !proc_fire)
      else $error("final byte processed while the output register was full");

endmodule
